@@ rtl/aws_pkg.sv @@
// ----------------------------------------------------------------------------
// aws_pkg
// Types and constants shared by the anagram window search and its checker.
// ----------------------------------------------------------------------------
package aws_pkg;

    localparam int MAX_PATTERN = 256;
    localparam int ALPHABET    = 26;
    localparam int BINS        = ALPHABET + 1;

    localparam int LETTER_W = 5;
    localparam int BIN_W    = $clog2(BINS);
    localparam int PTR_W    = $clog2(MAX_PATTERN);
    localparam int LEN_W    = $clog2(MAX_PATTERN + 1);
    localparam int CNT_W    = $clog2(MAX_PATTERN) + 2;
    localparam int MIS_W    = $clog2(BINS + 1);

    localparam int FIFO_DEPTH = 4;
    localparam int FPTR_W     = $clog2(FIFO_DEPTH);
    localparam int FCNT_W     = $clog2(FIFO_DEPTH + 1);

    typedef enum logic [1:0] {
        FN_CLEAR   = 2'd0,
        FN_PATTERN = 2'd1,
        FN_TEXT    = 2'd2,
        FN_NOP     = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        OP_NONE    = 2'd0,
        OP_CLEAR   = 2'd1,
        OP_PATTERN = 2'd2,
        OP_TEXT    = 2'd3
    } t_op;

    typedef struct packed {
        t_func               func;
        logic [LETTER_W-1:0] letter;
    } t_in_item;

    typedef struct packed {
        logic match;
        logic found;
        logic overflow;
    } t_out_item;

    typedef struct packed {
        t_op              kind;
        logic [BIN_W-1:0] bin;
        logic             leave;
        logic             add;
        logic             full;
        logic             ovf;
    } t_stage;

endpackage

@@ rtl/anagram_window_search.sv @@
// ----------------------------------------------------------------------------
// anagram_window_search
// Streaming search for permutations of a loaded pattern in a text stream.
// ----------------------------------------------------------------------------
// The block accepts one item per cycle: clear, pattern letter, text letter or no-op.
// Each text letter yields one result, which the third stage writes into the
// result buffer. The rate comes from a three-stage read-modify-write loop:
// the history ring is read in the first stage, the two count memories are read
// in the second, and the third stage writes one entry into each count memory,
// with the previous write forwarded to the next item. Input ready drops only
// while the four-entry result buffer, counting results still in the pipeline,
// is full.
// ----------------------------------------------------------------------------
module anagram_window_search
    import aws_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_data
);

    logic [LEN_W-1:0] r_plen, n_plen;
    logic [LEN_W-1:0] r_filled, n_filled;
    logic [PTR_W-1:0] r_wptr, n_wptr;
    logic             r_ovf, n_ovf;
    t_stage           r_p1, n_p1, r_p2;
    logic [BIN_W-1:0] r_old_bin, r_p2_old;

    logic [BIN_W-1:0] r_ring_mem [MAX_PATTERN];
    logic [CNT_W-1:0] r_enter_mem [BINS];
    logic [CNT_W-1:0] r_leave_mem [BINS];
    logic             r_enter_vld [BINS];
    logic             r_leave_vld [BINS];

    logic [CNT_W-1:0] r_en_new_q, r_en_old_q, r_lv_new_q, r_lv_old_q;

    logic             r_fe_vld, r_fl_vld;
    logic [BIN_W-1:0] r_fe_addr, r_fl_addr;
    logic [CNT_W-1:0] r_fe_data, r_fl_data;

    logic [MIS_W-1:0] r_mis, n_mis, mis_mid;
    logic             r_found, n_found;

    t_out_item         r_fifo [FIFO_DEPTH];
    logic [FPTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [FCNT_W-1:0] r_fcnt, credit;

    logic             accept, foreign, ring_we, pop, push, clr;
    logic [BIN_W-1:0] in_bin;
    logic [PTR_W-1:0] old_ptr;
    logic [CNT_W-1:0] en_new, en_old, lv_new, lv_old;
    logic [CNT_W-1:0] d_new, d_old, d_old_after, d_base;
    logic             enter_we, leave_we;
    logic [CNT_W-1:0] enter_wdata, leave_wdata;
    t_out_item        push_item;

    function automatic logic [CNT_W-1:0] pick(
        input logic [CNT_W-1:0] q,
        input logic             vld,
        input logic             hit,
        input logic [CNT_W-1:0] fwd
    );
        if (hit) begin
            return fwd;
        end else if (vld) begin
            return q;
        end
        return '0;
    endfunction

    function automatic logic [MIS_W-1:0] mis_step(
        input logic [MIS_W-1:0] mis,
        input logic [CNT_W-1:0] was,
        input logic [CNT_W-1:0] now
    );
        if (was != '0 && now == '0) begin
            return mis - MIS_W'(1);
        end else if (was == '0 && now != '0) begin
            return mis + MIS_W'(1);
        end
        return mis;
    endfunction

    assign credit = r_fcnt + FCNT_W'(r_p1.kind == OP_TEXT) + FCNT_W'(r_p2.kind == OP_TEXT);
    assign o_in_ready = (credit < FCNT_W'(FIFO_DEPTH));
    assign accept     = i_in_valid && o_in_ready;
    assign foreign    = !(i_in_data.letter < ALPHABET);
    assign in_bin     = foreign ? BIN_W'(ALPHABET) : BIN_W'(i_in_data.letter);

    always_comb begin
        if (LEN_W'(r_wptr) >= r_plen) begin
            old_ptr = PTR_W'(LEN_W'(r_wptr) - r_plen);
        end else begin
            old_ptr = PTR_W'(LEN_W'(r_wptr) + (LEN_W'(MAX_PATTERN) - r_plen));
        end
    end

    always_comb begin
        n_plen   = r_plen;
        n_filled = r_filled;
        n_wptr   = r_wptr;
        n_ovf    = r_ovf;
        n_p1     = '0;
        n_p1.kind = OP_NONE;
        n_p1.bin  = in_bin;
        ring_we  = 1'b0;
        if (accept) begin
            case (i_in_data.func)
                FN_CLEAR: begin
                    n_plen    = '0;
                    n_filled  = '0;
                    n_wptr    = '0;
                    n_ovf     = 1'b0;
                    n_p1.kind = OP_CLEAR;
                end
                FN_PATTERN: begin
                    if (!foreign) begin
                        if (r_plen >= LEN_W'(MAX_PATTERN)) begin
                            n_ovf = 1'b1;
                        end else begin
                            n_plen    = r_plen + LEN_W'(1);
                            n_p1.kind = OP_PATTERN;
                        end
                    end
                end
                FN_TEXT: begin
                    n_p1.kind = OP_TEXT;
                    ring_we   = 1'b1;
                    n_wptr    = (r_wptr == PTR_W'(MAX_PATTERN - 1)) ? '0 : r_wptr + PTR_W'(1);
                    if (r_plen != '0) begin
                        n_p1.add = 1'b1;
                        if (r_filled < r_plen) begin
                            n_filled = r_filled + LEN_W'(1);
                        end else begin
                            n_p1.leave = 1'b1;
                        end
                    end
                    n_p1.full = (n_filled == r_plen);
                    n_p1.ovf  = r_ovf;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_plen   <= '0;
            r_filled <= '0;
            r_wptr   <= '0;
            r_ovf    <= 1'b0;
            r_p1     <= '0;
            r_p2     <= '0;
        end else begin
            r_plen   <= n_plen;
            r_filled <= n_filled;
            r_wptr   <= n_wptr;
            r_ovf    <= n_ovf;
            r_p1     <= n_p1;
            r_p2     <= r_p1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ring_we) begin
            r_ring_mem[r_wptr] <= in_bin;
        end
        r_old_bin <= r_ring_mem[old_ptr];
        r_p2_old  <= r_old_bin;
    end

    always_ff @(posedge i_clk) begin
        if (enter_we) begin
            r_enter_mem[r_p2.bin] <= enter_wdata;
        end
        r_en_new_q <= r_enter_mem[r_p1.bin];
        r_en_old_q <= r_enter_mem[r_old_bin];
    end

    always_ff @(posedge i_clk) begin
        if (leave_we) begin
            r_leave_mem[r_p2_old] <= leave_wdata;
        end
        r_lv_new_q <= r_leave_mem[r_p1.bin];
        r_lv_old_q <= r_leave_mem[r_old_bin];
    end

    always_comb begin
        en_new = pick(r_en_new_q, r_enter_vld[r_p2.bin],
                      r_fe_vld && r_fe_addr == r_p2.bin, r_fe_data);
        lv_new = pick(r_lv_new_q, r_leave_vld[r_p2.bin],
                      r_fl_vld && r_fl_addr == r_p2.bin, r_fl_data);
        en_old = pick(r_en_old_q, r_enter_vld[r_p2_old],
                      r_fe_vld && r_fe_addr == r_p2_old, r_fe_data);
        lv_old = pick(r_lv_old_q, r_leave_vld[r_p2_old],
                      r_fl_vld && r_fl_addr == r_p2_old, r_fl_data);
        d_new       = en_new - lv_new;
        d_old       = en_old - lv_old;
        d_old_after = d_old - CNT_W'(1);
        d_base      = (r_p2.leave && r_p2.bin == r_p2_old) ? d_old_after : d_new;

        n_mis       = r_mis;
        mis_mid     = r_mis;
        n_found     = r_found;
        enter_we    = 1'b0;
        enter_wdata = en_new + CNT_W'(1);
        leave_we    = 1'b0;
        leave_wdata = lv_old + CNT_W'(1);
        push        = 1'b0;
        push_item   = '0;
        clr         = 1'b0;
        case (r_p2.kind)
            OP_CLEAR: begin
                clr     = 1'b1;
                n_mis   = '0;
                n_found = 1'b0;
            end
            OP_PATTERN: begin
                enter_we    = 1'b1;
                enter_wdata = en_new - CNT_W'(1);
                n_mis       = mis_step(r_mis, d_new, d_new - CNT_W'(1));
            end
            OP_TEXT: begin
                if (r_p2.leave) begin
                    leave_we = 1'b1;
                    mis_mid  = mis_step(r_mis, d_old, d_old_after);
                end
                n_mis = mis_mid;
                if (r_p2.add) begin
                    enter_we = 1'b1;
                    n_mis    = mis_step(mis_mid, d_base, d_base + CNT_W'(1));
                end
                push               = 1'b1;
                push_item.match    = r_p2.full && (n_mis == '0);
                push_item.found    = r_found || push_item.match;
                push_item.overflow = r_p2.ovf;
                n_found            = push_item.found;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || clr) begin
            r_fe_vld <= 1'b0;
            r_fl_vld <= 1'b0;
            for (int i = 0; i < BINS; i++) begin
                r_enter_vld[i] <= 1'b0;
                r_leave_vld[i] <= 1'b0;
            end
        end else begin
            if (enter_we) begin
                r_fe_vld              <= 1'b1;
                r_enter_vld[r_p2.bin] <= 1'b1;
            end
            if (leave_we) begin
                r_fl_vld              <= 1'b1;
                r_leave_vld[r_p2_old] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (enter_we) begin
            r_fe_addr <= r_p2.bin;
            r_fe_data <= enter_wdata;
        end
        if (leave_we) begin
            r_fl_addr <= r_p2_old;
            r_fl_data <= leave_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mis   <= '0;
            r_found <= 1'b0;
        end else begin
            r_mis   <= n_mis;
            r_found <= n_found;
        end
    end

    assign pop         = o_out_valid && i_out_ready;
    assign o_out_valid = (r_fcnt != '0);
    assign o_out_data  = r_fifo[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_fifo[r_wr_ptr] <= push_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fcnt   <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + FPTR_W'(1);
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + FPTR_W'(1);
            end
            r_fcnt <= r_fcnt + FCNT_W'(push) - FCNT_W'(pop);
        end
    end

endmodule

@@ rtl/aws_checker.sv @@
// ----------------------------------------------------------------------------
// aws_checker
// Port-level checks for the anagram window search, bound to its top level.
// ----------------------------------------------------------------------------
module aws_checker
    import aws_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_ready,
    input t_in_item  i_in_data,
    input logic      o_out_valid,
    input logic      i_out_ready,
    input t_out_item o_out_data
);

    // A stalled result holds its value until its transfer.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result changed or vanished while stalled");

    // Every accepted text letter shows a result after the pipeline latency.
    a_text_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && i_in_data.func == FN_TEXT |-> ##3 o_out_valid)
        else $error("text letter produced no result in time");

    // Input backpressure only appears while results are waiting.
    a_ready_backed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid)
        else $error("input stalled with no result pending");

    // A matching window always reports the search as found.
    a_match_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.match |-> o_out_data.found)
        else $error("match reported without found");

endmodule

bind anagram_window_search aws_checker u_aws_checker (.*);

@@ tb/anagram_window_search_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// anagram_window_search_checker
// Watches both channels of the anagram window search, keeps its own copy of
// the letter count differences, the mismatch count and the text history, and
// predicts the verdict of every text letter. Each output transfer is compared
// field by field with the oldest predicted verdict. Both channels are sampled
// on the falling clock edge, which shows what the next rising edge transfers.
// ----------------------------------------------------------------------------
module anagram_window_search_checker
    import aws_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      i_in_ready,
    input  t_in_item  i_in_data,
    input  logic      i_out_valid,
    input  logic      i_out_ready,
    input  t_out_item i_out_data,
    output int        o_fail_count,
    output int        o_pending
);

    int               count_gap [BINS];
    int               unbalanced_bins;
    logic [BIN_W-1:0] recent_text [MAX_PATTERN];
    int               text_ptr;
    int               pattern_size;
    int               window_fill;
    logic             found_seen;
    logic             overflow_seen;
    t_out_item        verdict_queue [$];
    t_out_item        oldest_verdict;
    int               fails = 0;

    assign o_fail_count = fails;

    task automatic report_mismatch(input string what);
        $display("%0t ns: mismatch: %s", $time, what);
        fails++;
    endtask

    task automatic check_field(input string name, input logic got, input logic want);
        if (got !== want) begin
            report_mismatch($sformatf("%s is %b, predicted %b", name, got, want));
        end
    endtask

    function automatic void clear_search();
        for (int b = 0; b < BINS; b++) begin
            count_gap[b] = 0;
        end
        unbalanced_bins = 0;
        text_ptr        = 0;
        pattern_size    = 0;
        window_fill     = 0;
        found_seen      = 1'b0;
        overflow_seen   = 1'b0;
    endfunction

    function automatic void shift_bin(input int b, input int delta);
        bit               was_off;
        logic [BIN_W-1:0] idx;
        idx     = BIN_W'(b);
        was_off = (count_gap[idx] != 0);
        count_gap[idx] += delta;
        if (was_off && count_gap[idx] == 0) begin
            unbalanced_bins--;
        end else if (!was_off && count_gap[idx] != 0) begin
            unbalanced_bins++;
        end
    endfunction

    function automatic void search_step(input t_in_item item);
        int        b;
        t_out_item verdict;
        b = (item.letter < ALPHABET) ? int'(item.letter) : ALPHABET;
        case (item.func)
            FN_CLEAR: begin
                clear_search();
            end
            FN_PATTERN: begin
                if (b < ALPHABET) begin
                    if (pattern_size >= MAX_PATTERN) begin
                        overflow_seen = 1'b1;
                    end else begin
                        pattern_size++;
                        shift_bin(b, -1);
                    end
                end
            end
            FN_TEXT: begin
                if (pattern_size != 0) begin
                    if (window_fill < pattern_size) begin
                        window_fill++;
                    end else begin
                        shift_bin(int'(recent_text[PTR_W'((text_ptr + MAX_PATTERN
                                                           - pattern_size) % MAX_PATTERN)]),
                                  -1);
                    end
                    shift_bin(b, 1);
                end
                recent_text[PTR_W'(text_ptr)] = b[BIN_W-1:0];
                text_ptr = (text_ptr + 1) % MAX_PATTERN;
                verdict.match = (window_fill == pattern_size && unbalanced_bins == 0);
                if (verdict.match) begin
                    found_seen = 1'b1;
                end
                verdict.found    = found_seen;
                verdict.overflow = overflow_seen;
                verdict_queue.push_back(verdict);
            end
            default: begin
            end
        endcase
    endfunction

    initial begin
        clear_search();
        o_pending = 0;
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            clear_search();
            verdict_queue.delete();
        end else begin
            if (i_in_valid && i_in_ready) begin
                search_step(i_in_data);
            end
            if (i_out_valid && i_out_ready) begin
                if (verdict_queue.size() == 0) begin
                    report_mismatch("result transfer with no text letter pending");
                end else begin
                    oldest_verdict = verdict_queue.pop_front();
                    check_field("match", i_out_data.match, oldest_verdict.match);
                    check_field("found", i_out_data.found, oldest_verdict.found);
                    check_field("overflow", i_out_data.overflow, oldest_verdict.overflow);
                end
            end
        end
        o_pending = verdict_queue.size();
    end

endmodule

@@ tb/anagram_window_search_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// anagram_window_search_test
// Stimulus and verdict for the anagram window search. A short directed run
// covers empty patterns, foreign letters, unused function codes and pattern
// growth after text; random runs then load small patterns and stream text
// built from shuffled copies of the pattern and nearby letters, with one run
// at the full pattern size that overflows it and wraps the text history.
// Both sides idle at random between transfers.
// ----------------------------------------------------------------------------
module anagram_window_search_test;
    import aws_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_ITEMS = 700;
    localparam int DRAIN_CYCLES = 16;

    typedef enum int {
        SEQ_WINDOW    = 0,
        SEQ_EMPTY     = 1,
        SEQ_GROW      = 2,
        SEQ_NOISE     = 3,
        SEQ_MORE_TEXT = 4,
        SEQ_LONG      = 5
    } t_seq;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    t_in_item  in_data;
    logic      out_valid;
    logic      out_ready;
    t_out_item out_data;
    int        fail_count;
    int        pending;

    logic [LETTER_W-1:0] pattern_letters [$];
    int                  pal_base;
    int                  pal_span;
    bit                  calm;
    int                  sent;
    int                  cycles;

    anagram_window_search DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    anagram_window_search_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_data   (out_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge clk);
            cycles++;
        end
        $display("anagram_window_search test failed");
        $finish;
    end

    initial begin
        int  stall;
        bit  took;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever begin
            stall = calm ? 0 : $urandom_range(0, 5);
            if (stall > 0) begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            took = 1'b0;
            while (!took) begin
                @(negedge clk);
                took = out_valid;
                @(posedge clk);
            end
        end
    end

    task automatic send_item(input t_func f, input logic [LETTER_W-1:0] l);
        int gap;
        bit took;
        gap = calm ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= '{func: f, letter: l};
        took = 1'b0;
        while (!took) begin
            @(negedge clk);
            took = in_ready;
            @(posedge clk);
        end
        if (f != FN_NOP) begin
            sent++;
        end
    endtask

    task automatic start_search();
        send_item(FN_CLEAR, LETTER_W'($urandom_range(0, 31)));
        pattern_letters.delete();
    endtask

    task automatic load_pattern(input int k, input int span);
        logic [LETTER_W-1:0] l;
        if (pattern_letters.size() == 0) begin
            pal_span = span;
            pal_base = $urandom_range(0, ALPHABET - 1 - span);
        end
        for (int i = 0; i < k; i++) begin
            if ($urandom_range(0, 7) == 0) begin
                send_item(FN_PATTERN, LETTER_W'($urandom_range(ALPHABET, 31)));
            end
            l = LETTER_W'(pal_base + $urandom_range(0, pal_span));
            pattern_letters.push_back(l);
            send_item(FN_PATTERN, l);
        end
    endtask

    task automatic send_shuffled_pattern();
        logic [LETTER_W-1:0] deck [$];
        logic [LETTER_W-1:0] hold;
        int                  j;
        deck = pattern_letters;
        for (int i = deck.size() - 1; i > 0; i--) begin
            j       = $urandom_range(0, i);
            hold    = deck[i];
            deck[i] = deck[j];
            deck[j] = hold;
        end
        foreach (deck[i]) begin
            send_item(FN_TEXT, deck[i]);
        end
    endtask

    task automatic send_palette_text(input int n);
        repeat (n) begin
            send_item(FN_TEXT, LETTER_W'(pal_base + $urandom_range(0, pal_span)));
        end
    endtask

    task automatic run_sequence(input t_seq kind);
        int k;
        case (kind)
            SEQ_WINDOW: begin
                start_search();
                k = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
                load_pattern(k, $urandom_range(0, 4));
                repeat ($urandom_range(2, 6)) begin
                    case ($urandom_range(0, 9))
                        0, 1, 2, 3, 4: send_shuffled_pattern();
                        5, 6, 7:       send_palette_text($urandom_range(1, k));
                        8:             send_item(FN_TEXT,
                                                 LETTER_W'($urandom_range(ALPHABET, 31)));
                        default:       send_item(FN_NOP, LETTER_W'($urandom_range(0, 31)));
                    endcase
                end
            end
            SEQ_EMPTY: begin
                start_search();
                repeat ($urandom_range(3, 12)) begin
                    send_item(FN_TEXT, LETTER_W'($urandom_range(0, 31)));
                end
            end
            SEQ_GROW: begin
                start_search();
                load_pattern($urandom_range(1, 4), $urandom_range(1, 3));
                send_shuffled_pattern();
                send_palette_text($urandom_range(0, 3));
                load_pattern($urandom_range(1, 3), pal_span);
                send_shuffled_pattern();
                send_shuffled_pattern();
            end
            SEQ_NOISE: begin
                repeat ($urandom_range(8, 20)) begin
                    send_item(t_func'($urandom_range(0, 3)), LETTER_W'($urandom_range(0, 31)));
                end
            end
            SEQ_MORE_TEXT: begin
                if (pattern_letters.size() != 0) begin
                    send_shuffled_pattern();
                end
                send_palette_text($urandom_range(3, 10));
            end
            default: begin
                start_search();
                load_pattern(MAX_PATTERN, ALPHABET - 1);
                repeat ($urandom_range(1, 4)) begin
                    send_item(FN_PATTERN, LETTER_W'($urandom_range(0, ALPHABET - 1)));
                end
                send_shuffled_pattern();
                send_palette_text(12);
            end
        endcase
    endtask

    initial begin
        int   pick;
        bit   long_done;
        t_seq kind;

        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        out_ready = 1'b0;
        calm      = 1'b0;
        sent      = 0;
        pal_base  = 0;
        pal_span  = 0;
        long_done = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        send_item(FN_TEXT, 5'd0);
        send_item(FN_TEXT, 5'd31);
        send_item(FN_NOP, 5'd31);
        send_item(FN_PATTERN, 5'd0);
        send_item(FN_PATTERN, 5'd31);
        send_item(FN_PATTERN, 5'd25);
        send_item(FN_PATTERN, 5'd26);
        send_item(FN_TEXT, 5'd25);
        send_item(FN_TEXT, 5'd0);
        send_item(FN_TEXT, 5'd31);
        send_item(FN_TEXT, 5'd0);
        send_item(FN_TEXT, 5'd25);
        send_item(FN_PATTERN, 5'd7);
        send_item(FN_TEXT, 5'd7);
        send_item(FN_TEXT, 5'd3);
        send_item(FN_CLEAR, 5'd31);
        send_item(FN_PATTERN, 5'd3);
        send_item(FN_TEXT, 5'd4);
        send_item(FN_TEXT, 5'd3);
        send_item(FN_NOP, 5'd0);
        send_item(FN_CLEAR, 5'd0);

        sent = 0;
        while (sent < RANDOM_ITEMS || !long_done) begin
            calm = ($urandom_range(0, 3) == 0);
            if (!long_done && sent > RANDOM_ITEMS / 3) begin
                run_sequence(SEQ_LONG);
                long_done = 1'b1;
            end else begin
                pick = $urandom_range(0, 9);
                kind = (pick < 6) ? SEQ_WINDOW : t_seq'(pick - 5);
                run_sequence(kind);
            end
        end
        in_valid <= 1'b0;

        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0) begin
            $display("anagram_window_search test passed");
        end else begin
            $display("anagram_window_search test failed");
        end
        $finish;
    end

endmodule

@@ sim.f @@
rtl/aws_pkg.sv
rtl/anagram_window_search.sv
rtl/aws_checker.sv
tb/anagram_window_search_checker.sv
tb/anagram_window_search_test.sv
